// ----- hw/rtl/cclc_pkg.sv -----
// ----------------------------------------------------------------------------
// Cyclotomic coset leader check: shared definitions
// Field widths, microcode encodings, the control store and the status bundle
// that passes between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cclc_pkg;

   localparam int EXP_W = 62;
   localparam int VAL_W = 63;
   localparam int DIM_W = 6;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(5);
   localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
   localparam logic [DIM_W-1:0] MAX_DIM   = DIM_W'(63);

   // Required gcd for odd and even dimensions.
   localparam logic [VAL_W-1:0] GCD_ODD  = VAL_W'(1);
   localparam logic [VAL_W-1:0] GCD_EVEN = VAL_W'(3);

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_INIT,
      OP_GCD,
      OP_SAVE,
      OP_ROT,
      OP_PUBLISH
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_OOR,
      COND_U_NE_V,
      COND_GCD_BAD,
      COND_ROT_MORE,
      COND_RSP_BUSY
   } cond_type;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_CHECK,
      STEP_GCD,
      STEP_SAVE,
      STEP_ROT,
      STEP_DONE
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jmp_t;
      step_type jmp_f;
   } cword_type;

   typedef struct packed {
      logic oor;
      logic u_ne_v;
      logic gcd_bad;
      logic rot_more;
   } status_type;

   // Control store. The next step is jmp_t when the condition holds,
   // otherwise jmp_f.
   function automatic cword_type ucode_rom(input step_type step);
      cword_type w;
      begin
         unique case (step)
            STEP_IDLE:  w = '{OP_LOAD,    COND_NO_REQ,   STEP_IDLE, STEP_CHECK};
            STEP_CHECK: w = '{OP_INIT,    COND_OOR,      STEP_DONE, STEP_GCD};
            STEP_GCD:   w = '{OP_GCD,     COND_U_NE_V,   STEP_GCD,  STEP_SAVE};
            STEP_SAVE:  w = '{OP_SAVE,    COND_GCD_BAD,  STEP_DONE, STEP_ROT};
            STEP_ROT:   w = '{OP_ROT,     COND_ROT_MORE, STEP_ROT,  STEP_DONE};
            STEP_DONE:  w = '{OP_PUBLISH, COND_RSP_BUSY, STEP_DONE, STEP_IDLE};
            default:    w = '{OP_PUBLISH, COND_ALWAYS,   STEP_IDLE, STEP_IDLE};
         endcase
         return w;
      end
   endfunction

endpackage

// ----- hw/rtl/cclc_datapath.sv -----
// ----------------------------------------------------------------------------
// Cyclotomic coset leader check: datapath
// Binary extended gcd against the modulus and modular doubling of the
// exponent and its inverse, one step per cycle under microcode control.
// ----------------------------------------------------------------------------
module cclc_datapath (
   input  logic                        clock,
   input  cclc_pkg::op_type            op,
   input  logic [cclc_pkg::EXP_W-1:0]  req_exponent,
   input  logic [cclc_pkg::DIM_W-1:0]  dimension,
   output cclc_pkg::status_type        status,
   output logic [cclc_pkg::EXP_W-1:0]  res_exponent,
   output logic                        res_is_leader,
   output logic                        res_out_of_range,
   output logic [cclc_pkg::VAL_W-1:0]  res_gcd,
   output logic [cclc_pkg::VAL_W-1:0]  res_inverse
);
   import cclc_pkg::*;

   logic [EXP_W-1:0] e_ff;
   logic [DIM_W-1:0] n_ff;
   logic [VAL_W-1:0] m_ff;
   logic [VAL_W-1:0] u_ff, v_ff, x1_ff, x2_ff;
   logic [VAL_W-1:0] g_ff, inv_ff;
   logic [DIM_W-1:0] k_ff;
   logic             leader_ff, oor_ff;

   logic [VAL_W-1:0] m_calc;
   logic             oor_calc;
   logic [VAL_W:0]   d_uv, d_vu;
   logic [VAL_W-1:0] dbl_u, dbl_x;
   logic             rot_fail;
   logic [DIM_W-1:0] k_next;

   // Halve modulo an odd m: an odd value first has m added.
   function automatic logic [VAL_W-1:0] half_mod(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] m);
      logic [VAL_W:0] s;
      begin
         s = x[0] ? ({1'b0, x} + {1'b0, m}) : {1'b0, x};
         return s[VAL_W:1];
      end
   endfunction

   function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b,
                                                input logic [VAL_W-1:0] m);
      logic [VAL_W:0] d;
      begin
         d = {1'b0, a} - {1'b0, b};
         return d[VAL_W] ? (d[VAL_W-1:0] + m) : d[VAL_W-1:0];
      end
   endfunction

   // Twice r modulo m, for r below m.
   function automatic logic [VAL_W-1:0] dbl_mod(input logic [VAL_W-1:0] r,
                                                input logic [VAL_W-1:0] m);
      logic [VAL_W+1:0] t;
      begin
         t = {1'b0, r, 1'b0} - {2'b00, m};
         return t[VAL_W+1] ? {r[VAL_W-2:0], 1'b0} : t[VAL_W-1:0];
      end
   endfunction

   assign m_calc   = VAL_W'((65'(1) << n_ff) - 65'(1));
   assign oor_calc = (n_ff < DIM_MIN) || (n_ff > MAX_DIM) || (e_ff == '0) || !e_ff[0]
                     || ((VAL_W'(e_ff) & ~(m_calc >> 1)) != '0);

   assign d_uv = {1'b0, u_ff} - {1'b0, v_ff};
   assign d_vu = {1'b0, v_ff} - {1'b0, u_ff};

   assign dbl_u    = dbl_mod(u_ff, m_ff);
   assign dbl_x    = dbl_mod(x1_ff, m_ff);
   assign rot_fail = (dbl_u < VAL_W'(e_ff)) || (n_ff[0] && (dbl_x < VAL_W'(e_ff)));
   assign k_next   = k_ff + DIM_W'(1);

   assign status.oor      = oor_calc;
   assign status.u_ne_v   = (u_ff != v_ff);
   assign status.gcd_bad  = n_ff[0] ? (u_ff != GCD_ODD) : (u_ff != GCD_EVEN);
   assign status.rot_more = (k_next != n_ff) && !rot_fail;

   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            e_ff <= req_exponent;
            n_ff <= dimension;
         end
         OP_INIT: begin
            oor_ff    <= oor_calc;
            m_ff      <= m_calc;
            u_ff      <= VAL_W'(e_ff);
            v_ff      <= m_calc;
            x1_ff     <= VAL_W'(1);
            x2_ff     <= '0;
            g_ff      <= '0;
            inv_ff    <= '0;
            leader_ff <= 1'b0;
         end
         OP_GCD: begin
            // Both values stay odd except the one just reduced, which is
            // halved until odd again before the next subtraction.
            if (u_ff != v_ff) begin
               if (!u_ff[0]) begin
                  u_ff  <= u_ff >> 1;
                  x1_ff <= half_mod(x1_ff, m_ff);
               end else if (!v_ff[0]) begin
                  v_ff  <= v_ff >> 1;
                  x2_ff <= half_mod(x2_ff, m_ff);
               end else if (!d_uv[VAL_W]) begin
                  u_ff  <= d_uv[VAL_W-1:0];
                  x1_ff <= sub_mod(x1_ff, x2_ff, m_ff);
               end else begin
                  v_ff  <= d_vu[VAL_W-1:0];
                  x2_ff <= sub_mod(x2_ff, x1_ff, m_ff);
               end
            end
         end
         OP_SAVE: begin
            g_ff      <= u_ff;
            leader_ff <= !status.gcd_bad;
            if (n_ff[0] && (u_ff == GCD_ODD)) begin
               inv_ff <= x1_ff;
            end
            u_ff <= VAL_W'(e_ff);
            k_ff <= '0;
         end
         OP_ROT: begin
            u_ff  <= dbl_u;
            x1_ff <= dbl_x;
            k_ff  <= k_next;
            if (rot_fail) begin
               leader_ff <= 1'b0;
            end
         end
         OP_PUBLISH: begin
         end
         default: begin
         end
      endcase
   end

   assign res_exponent     = e_ff;
   assign res_is_leader    = leader_ff;
   assign res_out_of_range = oor_ff;
   assign res_gcd          = g_ff;
   assign res_inverse      = inv_ff;

endmodule

// ----- hw/rtl/cyclotomic_coset_leader_check_top.sv -----
// ----------------------------------------------------------------------------
// Cyclotomic coset leader check: top level
// Microcode sequencer, dimension register and result register.
// ----------------------------------------------------------------------------
// One exponent is checked at a time. An item goes through set-up (load, then
// init), the binary extended gcd against 2^n-1 (one subtraction or one halving
// a step), a step to keep the gcd, one doubling per step of the rotation test
// (at most n doublings), and a publish step. Out of range items go from set-up
// straight to publish, and a gcd that is not the required one skips the rotation test.
// The next item is accepted once the result register has been loaded, even
// while that result still waits to be taken.
module cyclotomic_coset_leader_check_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [cclc_pkg::EXP_W-1:0]  req_exponent,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [cclc_pkg::EXP_W-1:0]  rsp_exponent_echo,
   output logic                        rsp_is_leader,
   output logic                        rsp_out_of_range,
   output logic [cclc_pkg::VAL_W-1:0]  rsp_gcd_value,
   output logic [cclc_pkg::VAL_W-1:0]  rsp_inverse_value,
   input  logic                        csr_wr_en,
   input  logic [cclc_pkg::DIM_W-1:0]  csr_wr_data
);
   import cclc_pkg::*;

   step_type         pc_ff, pc_in;
   cword_type        cword;
   status_type       status;
   logic             cond_met;
   logic             rsp_busy;
   logic             rsp_load;
   logic [DIM_W-1:0] dim_ff;
   logic             rsp_valid_ff;

   logic [EXP_W-1:0] res_exponent;
   logic             res_is_leader, res_out_of_range;
   logic [VAL_W-1:0] res_gcd, res_inverse;

   logic [EXP_W-1:0] rsp_exponent_ff;
   logic             rsp_is_leader_ff, rsp_out_of_range_ff;
   logic [VAL_W-1:0] rsp_gcd_ff, rsp_inverse_ff;

   assign cword    = ucode_rom(pc_ff);
   assign rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_load = (cword.op == OP_PUBLISH) && !rsp_busy;

   always_comb begin
      unique case (cword.cond)
         COND_ALWAYS:   cond_met = 1'b1;
         COND_NO_REQ:   cond_met = !req_valid;
         COND_OOR:      cond_met = status.oor;
         COND_U_NE_V:   cond_met = status.u_ne_v;
         COND_GCD_BAD:  cond_met = status.gcd_bad;
         COND_ROT_MORE: cond_met = status.rot_more;
         COND_RSP_BUSY: cond_met = rsp_busy;
         default:       cond_met = 1'b1;
      endcase
   end

   assign pc_in = cond_met ? cword.jmp_t : cword.jmp_f;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         dim_ff       <= DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (csr_wr_en) begin
            dim_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_exponent_ff     <= res_exponent;
         rsp_is_leader_ff    <= res_is_leader;
         rsp_out_of_range_ff <= res_out_of_range;
         rsp_gcd_ff          <= res_gcd;
         rsp_inverse_ff      <= res_inverse;
      end
   end

   cclc_datapath u_datapath (
      .clock            (clock),
      .op               (cword.op),
      .req_exponent     (req_exponent),
      .dimension        (dim_ff),
      .status           (status),
      .res_exponent     (res_exponent),
      .res_is_leader    (res_is_leader),
      .res_out_of_range (res_out_of_range),
      .res_gcd          (res_gcd),
      .res_inverse      (res_inverse)
   );

   assign req_stall         = (pc_ff != STEP_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_exponent_echo = rsp_exponent_ff;
   assign rsp_is_leader     = rsp_is_leader_ff;
   assign rsp_out_of_range  = rsp_out_of_range_ff;
   assign rsp_gcd_value     = rsp_gcd_ff;
   assign rsp_inverse_value = rsp_inverse_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pc_ff == STEP_DONE))
      else $error("result item appeared outside the publish step");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_gcd_value == '0 && !rsp_is_leader && rsp_inverse_value == '0))
      else $error("out of range item carries a gcd, inverse or verdict");

   a_leader_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_leader) |-> (rsp_gcd_value == GCD_ODD || rsp_gcd_value == GCD_EVEN))
      else $error("leader reported with a gcd other than one or three");

   a_inverse_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inverse_value != '0) |-> (rsp_gcd_value == GCD_ODD))
      else $error("inverse reported for an exponent not coprime to the modulus");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cyclotomic coset leader check: testbench
// Sends candidate exponents under many dimension settings, works out each
// verdict with an independent model and compares every returned item field
// by field, while the request channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb;
   import cclc_pkg::*;

   typedef struct {
      logic [EXP_W-1:0] exponent_echo;
      logic             is_leader;
      logic             out_of_range;
      logic [VAL_W-1:0] gcd_value;
      logic [VAL_W-1:0] inverse_value;
   } verdict_type;

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_stall;
   logic [EXP_W-1:0] req_exponent = '0;
   logic             rsp_valid;
   logic             rsp_stall    = 1'b0;
   logic [EXP_W-1:0] rsp_exponent_echo;
   logic             rsp_is_leader;
   logic             rsp_out_of_range;
   logic [VAL_W-1:0] rsp_gcd_value;
   logic [VAL_W-1:0] rsp_inverse_value;
   logic             csr_wr_en    = 1'b0;
   logic [DIM_W-1:0] csr_wr_data  = '0;

   verdict_type      expected_verdicts[$];
   logic [DIM_W-1:0] dimension_shadow = DIM_RESET;
   int               error_count      = 0;
   bit               quiet_phase      = 1'b0;

   cyclotomic_coset_leader_check_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_exponent      (req_exponent),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_exponent_echo (rsp_exponent_echo),
      .rsp_is_leader     (rsp_is_leader),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_gcd_value     (rsp_gcd_value),
      .rsp_inverse_value (rsp_inverse_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // True when no doubling of start modulo m, for one to n doublings, falls below e.
   function automatic bit rotations_stay_above(input bit [63:0] start, input bit [63:0] e,
                                               input bit [63:0] m, input int n);
      bit [63:0] r;
      int        k;
      r = start;
      for (k = 0; k < n; k++) begin
         r = (r << 1) % m;
         if (r < e) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic verdict_type predict_verdict(input logic [EXP_W-1:0] exponent,
                                                   input logic [DIM_W-1:0] dim);
      verdict_type v;
      bit [63:0]   e, m, emax, a, b, t, g, q, r0, r1, r2, t0, t1, t2, qt, s;
      int          n;
      e = 64'(exponent);
      n = int'(dim);
      m = '0;
      v.exponent_echo = exponent;
      v.is_leader     = 1'b0;
      v.out_of_range  = 1'b1;
      v.gcd_value     = '0;
      v.inverse_value = '0;
      if (dim >= DIM_MIN && dim <= MAX_DIM) begin
         m    = (64'd1 << n) - 64'd1;
         emax = (64'd1 << (n - 1)) - 64'd1;
         v.out_of_range = (e == 0) || !e[0] || (e > emax);
      end
      if (!v.out_of_range) begin
         a = m;
         b = e;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         g = a;
         v.gcd_value = VAL_W'(g);
         if (n % 2 == 1) begin
            if (g == 1) begin
               // Extended Euclid with the coefficients held as residues modulo m;
               // the product q*t1 is formed by shift and add to stay below 2^64.
               r0 = m;
               r1 = e;
               t0 = 0;
               t1 = 1;
               while (r1 != 0) begin
                  q  = r0 / r1;
                  r2 = r0 - q * r1;
                  a  = q % m;
                  b  = t1;
                  qt = 0;
                  while (b != 0) begin
                     if (b[0]) begin
                        s  = qt + a;
                        qt = (s >= m) ? s - m : s;
                     end
                     s = a + a;
                     a = (s >= m) ? s - m : s;
                     b = b >> 1;
                  end
                  t2 = (t0 >= qt) ? t0 - qt : t0 + (m - qt);
                  r0 = r1;
                  r1 = r2;
                  t0 = t1;
                  t1 = t2;
               end
               v.inverse_value = VAL_W'(t0);
               v.is_leader = rotations_stay_above(e, e, m, n) &&
                             rotations_stay_above(t0, e, m, n);
            end
         end else if (g == 3) begin
            v.is_leader = rotations_stay_above(e, e, m, n);
         end
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < 50)
         $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                  $time, what, got, want);
      error_count++;
   endtask

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_exponent(input logic [EXP_W-1:0] exponent);
      int gap;
      gap = quiet_phase ? 0 : idle_length();
      if (gap > 0) begin
         req_valid    <= 1'b0;
         req_exponent <= EXP_W'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_exponent <= exponent;
      do @(posedge clock); while (req_stall);
      expected_verdicts.push_back(predict_verdict(exponent, dimension_shadow));
   endtask

   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_dimension(input logic [DIM_W-1:0] dim);
      wait_for_verdicts();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dim;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      dimension_shadow  = dim;
   endtask

   task automatic test_reset_dimension();
      send_exponent('0);
      send_exponent(EXP_W'(2));
      send_exponent(EXP_W'(1));
      send_exponent(EXP_W'(15));
      send_exponent(EXP_W'(17));
      send_exponent({EXP_W{1'b1}});
      send_exponent(EXP_W'(7));
      send_exponent(EXP_W'(11));
   endtask

   task automatic test_largest_dimensions();
      write_dimension(MAX_DIM);
      send_exponent(EXP_W'(1));
      send_exponent({EXP_W{1'b1}});
      send_exponent({{(EXP_W-2){1'b1}}, 2'b01});
      send_exponent(EXP_W'(3));
      send_exponent({{(EXP_W-1){1'b1}}, 1'b0});
      write_dimension(MAX_DIM - DIM_W'(1));
      send_exponent({1'b0, {(EXP_W-1){1'b1}}});
      send_exponent(EXP_W'(3));
   endtask

   task automatic test_even_dimension();
      write_dimension(DIM_W'(6));
      send_exponent(EXP_W'(1));
      send_exponent(EXP_W'(3));
      send_exponent(EXP_W'(9));
      send_exponent(EXP_W'(31));
      send_exponent(EXP_W'(33));
   endtask

   // Dimensions below the legal range, then the smallest legal one.
   task automatic test_dimension_edges();
      write_dimension(DIM_W'(0));
      send_exponent(EXP_W'(1));
      write_dimension(DIM_W'(1));
      send_exponent({EXP_W{1'b1}});
      write_dimension(DIM_MIN);
      send_exponent(EXP_W'(1));
      send_exponent(EXP_W'(3));
   endtask

   task automatic test_random_phases();
      logic [DIM_W-1:0] dim;
      logic [EXP_W-1:0] e;
      bit [63:0]        emax, pick, count;
      int               n, kind, phase, item;
      for (phase = 0; phase < 15; phase++) begin
         kind = $urandom_range(0, 99);
         if (phase == 0)      dim = DIM_MIN;
         else if (phase == 1) dim = MAX_DIM;
         else if (kind < 65)  dim = DIM_W'($urandom_range(2, 12));
         else if (kind < 85)  dim = DIM_W'($urandom_range(13, 40));
         else if (kind < 97)  dim = DIM_W'($urandom_range(41, 63));
         else                 dim = DIM_W'($urandom_range(0, 1));
         write_dimension(dim);
         quiet_phase = ($urandom_range(0, 3) == 0);
         n = int'(dim);
         for (item = 0; item < 50; item++) begin
            kind = $urandom_range(0, 99);
            pick = {$urandom, $urandom};
            if (n < 2) begin
               e = (kind < 50) ? EXP_W'(pick) : EXP_W'($urandom_range(0, 7));
            end else begin
               emax = (64'd1 << (n - 1)) - 64'd1;
               if (kind < 72) begin
                  // Legal odd exponents; for even n often a multiple of three.
                  if (n % 2 == 0 && n >= 4 && $urandom_range(0, 2) == 0) begin
                     count = (emax / 3 + 1) / 2;
                     e = EXP_W'(3 * (2 * (pick % count) + 1));
                  end else if ($urandom_range(0, 9) == 0) begin
                     e = $urandom_range(0, 1) ? EXP_W'(1) : EXP_W'(emax);
                  end else begin
                     e = EXP_W'(2 * (pick & ((64'd1 << (n - 2)) - 64'd1)) + 1);
                  end
               end else if (kind < 80) begin
                  e = EXP_W'(pick & emax & ~64'd1);
               end else if (kind < 88) begin
                  e = (n < 63) ? EXP_W'(pick | (64'd1 << (n - 1))) : EXP_W'(pick);
               end else if (kind < 91) begin
                  e = '0;
               end else begin
                  e = EXP_W'(pick);
               end
            end
            send_exponent(e);
         end
      end
      quiet_phase = 1'b0;
   endtask

   initial begin : rsp_stall_gen
      int len;
      forever begin
         len = quiet_phase ? 0 : idle_length();
         if (len > 0) begin
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("item with nothing expected, exponent",
                            64'(rsp_exponent_echo), '0);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_exponent_echo !== want.exponent_echo)
               report_mismatch("exponent_echo", 64'(rsp_exponent_echo),
                               64'(want.exponent_echo));
            if (rsp_is_leader !== want.is_leader)
               report_mismatch("is_leader", 64'(rsp_is_leader), 64'(want.is_leader));
            if (rsp_out_of_range !== want.out_of_range)
               report_mismatch("out_of_range", 64'(rsp_out_of_range),
                               64'(want.out_of_range));
            if (rsp_gcd_value !== want.gcd_value)
               report_mismatch("gcd_value", 64'(rsp_gcd_value), 64'(want.gcd_value));
            if (rsp_inverse_value !== want.inverse_value)
               report_mismatch("inverse_value", 64'(rsp_inverse_value),
                               64'(want.inverse_value));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_dimension();
      test_largest_dimensions();
      test_even_dimension();
      test_dimension_edges();
      test_random_phases();
      wait_for_verdicts();
      // Anything returned after this point has no expectation and is flagged.
      repeat (400) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
